// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the remix block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/acrfc_pkg.sv
// Shared types and codes for the channel remix / format convert block.
// No dependencies; used by acrfc_mix, acrfc_enc and the top level.
package acrfc_pkg;

    localparam int SampleW = 16;
    localparam int WordW   = 32;
    localparam int NumCh   = 6;
    localparam int AddrW   = 4;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [19:0]        wide_t;
    typedef logic [WordW-1:0]          word_t;

    typedef struct packed {
        sample_t [NumCh-1:0] smp;
        logic    [2:0]       cnt;
    } mix_t;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd0;
    localparam logic [1:0] REG_TARGET_MODE     = 2'd1;
    localparam logic [1:0] REG_SAMPLE_FORMAT   = 2'd2;

    // target layouts
    localparam logic [3:0] MODE_MONO     = 4'd0;
    localparam logic [3:0] MODE_STEREO   = 4'd1;
    localparam logic [3:0] MODE_2_1      = 4'd2;
    localparam logic [3:0] MODE_3_0      = 4'd3;
    localparam logic [3:0] MODE_3_1      = 4'd4;
    localparam logic [3:0] MODE_2F1R     = 4'd5;
    localparam logic [3:0] MODE_2F1R_LFE = 4'd6;
    localparam logic [3:0] MODE_2F2R     = 4'd7;
    localparam logic [3:0] MODE_3F1R     = 4'd9;
    localparam logic [3:0] MODE_3F1R_LFE = 4'd10;
    localparam logic [3:0] MODE_5_0      = 4'd11;
    localparam logic [3:0] MODE_5_1      = 4'd12;

    // output encodings
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S24 = 3'd2;
    localparam logic [2:0] FMT_S32 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;

endpackage

// File: rtl/acrfc_mix.sv
// Remix stage: maps one source frame onto the target layout.
// Depends on acrfc_pkg.
module acrfc_mix
    import acrfc_pkg::*;
(
    input  sample_t [NumCh-1:0] ch,
    input  logic    [2:0]       source_channels,
    input  logic    [3:0]       target_mode,
    output mix_t                mix
);

    function automatic sample_t clamp16(input wide_t x);
        if (x < -wide_t'(32768))
            return sample_t'(-32768);
        else if (x > wide_t'(32767))
            return sample_t'(32767);
        else
            return sample_t'(x);
    endfunction

    function automatic sample_t fold(input wide_t base, input wide_t sum);
        return clamp16(base + sum - (sum >>> 2));
    endfunction

    logic [2:0]          n;
    logic [3:0]          mode;
    logic [3:0]          native_code;
    logic                lfe;
    logic                pair_src;
    sample_t [NumCh-1:0] c;
    wide_t   [NumCh-1:0] wc;
    wide_t               s;
    wide_t               sum;
    sample_t             avg;
    sample_t [NumCh-1:0] smp;
    logic    [2:0]       cnt;

    always_comb
    begin
        n = source_channels;
        if (n == 3'd0)
            n = 3'd1;
        if (n == 3'd7)
            n = 3'd6;
        mode = (target_mode > MODE_5_1) ? MODE_5_1 : target_mode;
        lfe = (mode == MODE_2_1) || (mode == MODE_3_1) ||
              ((mode >= MODE_2F1R) && !mode[0]);
        pair_src = (n == 3'd2) || (n == 3'd4);

        case (n)
            3'd1:    native_code = MODE_MONO;
            3'd2:    native_code = MODE_STEREO;
            3'd3:    native_code = MODE_3_0;
            3'd4:    native_code = MODE_2F2R;
            3'd5:    native_code = MODE_5_0;
            default: native_code = MODE_5_1;
        endcase

        c = '0;
        case (n)
            3'd1:
            begin
                c[0] = ch[0];
                c[2] = ch[0];
            end
            3'd2:
            begin
                c[0] = ch[0];
                c[2] = ch[1];
            end
            3'd3:
            begin
                c[0] = ch[0];
                c[1] = ch[1];
                c[2] = ch[2];
            end
            3'd4:
            begin
                // second rear sits in the fourth word
                c[0] = ch[0];
                c[2] = ch[1];
                c[3] = ch[2];
                c[4] = ch[3];
            end
            default:
            begin
                c[4:0] = ch[4:0];
                if (n > 3'd5)
                    c[5] = ch[5];
            end
        endcase

        for (int i = 0; i < NumCh; i++)
            wc[i] = wide_t'(c[i]);
        avg = sample_t'((wc[0] + wc[2]) >>> 1);
        s   = '0;
        sum = '0;
        smp = '0;
        cnt = 3'd0;

        if (native_code == mode)
        begin
            for (int i = 0; i < NumCh; i++)
                if (3'(i) < n)
                    smp[i] = ch[i];
            cnt = n;
        end
        else if (mode == MODE_MONO)
        begin
            s = wc[0] + wc[2];
            if (n > 3'd2)
            begin
                sum = (wc[1] <<< 1) + wc[3] + wc[4];
                smp[0] = clamp16((s + sum - (sum >>> 2)) >>> 1);
            end
            else
                smp[0] = sample_t'(s >>> 1);
            cnt = 3'd1;
        end
        else if (mode <= MODE_2_1)
        begin
            smp[0] = (n > 3'd2) ? fold(wc[0], wc[1] + wc[3]) : c[0];
            smp[1] = (n > 3'd2) ? fold(wc[2], wc[1] + wc[4]) : c[2];
            cnt = 3'd2;
            if (lfe)
            begin
                smp[cnt] = c[5];
                cnt = cnt + 3'd1;
            end
        end
        else if (mode <= MODE_3_1)
        begin
            smp[0] = fold(wc[0], wc[3]);
            smp[1] = pair_src ? avg : c[1];
            smp[2] = fold(wc[2], wc[4]);
            cnt = 3'd3;
            if (lfe)
            begin
                smp[cnt] = c[5];
                cnt = cnt + 3'd1;
            end
        end
        else
        begin
            if (mode >= MODE_3F1R)
            begin
                smp[0] = c[0];
                smp[1] = pair_src ? avg : c[1];
                smp[2] = c[2];
                cnt = 3'd3;
            end
            else
            begin
                // fold centre into both fronts
                smp[0] = fold(wc[0], wc[1]);
                smp[1] = fold(wc[2], wc[1]);
                cnt = 3'd2;
            end
            if ((mode == MODE_2F1R) || (mode == MODE_2F1R_LFE) ||
                (mode == MODE_3F1R) || (mode == MODE_3F1R_LFE))
            begin
                smp[cnt] = sample_t'((wc[3] + wc[4]) >>> 1);
                cnt = cnt + 3'd1;
            end
            else
            begin
                smp[cnt] = c[3];
                cnt = cnt + 3'd1;
                smp[cnt] = c[4];
                cnt = cnt + 3'd1;
            end
            if (lfe)
            begin
                smp[cnt] = c[5];
                cnt = cnt + 3'd1;
            end
        end

        mix.smp = smp;
        mix.cnt = cnt;
    end

endmodule

// File: rtl/acrfc_enc.sv
// Format stage: encodes each remixed sample as u8, s16, s24, s32 or float32.
// Depends on acrfc_pkg.
module acrfc_enc
    import acrfc_pkg::*;
(
    input  mix_t              mix,
    input  logic [2:0]        sample_format,
    output word_t [NumCh-1:0] word
);

    function automatic word_t encode(input sample_t v, input logic [2:0] fmt);
        logic [16:0] m;
        logic [16:0] norm;
        logic [4:0]  p;
        logic [7:0]  expo;
        word_t       r;
        m = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        p = 5'd0;
        for (int k = 0; k < 17; k++)
            if (m[k])
                p = 5'(k);
        norm = m << (5'd16 - p);
        expo = 8'(p) + 8'd112;
        case (fmt)
            FMT_U8:  r = {24'd0, ~v[15], v[14:8]};
            FMT_S16: r = {16'd0, v};
            FMT_S24: r = {8'd0, v, 8'd0};
            FMT_S32: r = {{8{v[15]}}, v, 8'd0};
            FMT_F32: r = (v == '0) ? '0 : {v[15], expo, norm[15:0], 7'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NumCh; i++)
            word[i] = (3'(i) < mix.cnt) ? encode(mix.smp[i], sample_format) : '0;
    end

endmodule

// File: rtl/audio_channel_remix_format_convert_unit.sv
// Surround remix and sample-format converter, one frame per word.
// Input channel: in_valid/in_stall carry one frame of six signed 16-bit
// samples (those beyond source_channels are ignored) and in_last.
// Output channel: out_valid/out_stall carry up to six encoded samples,
// right aligned in 32 bits, with out_count and out_last; samples at or
// beyond out_count read as zero.
// Configuration: APB-style port, source_channels at 0x0, target_mode at
// 0x4, sample_format at 0x8; write only while no word is in flight.
// Pipeline: input register, remix register, encode/output register.
// An accepted word passes through these three registers in order;
// one word is taken every cycle while the output is not stalled.
// When out_stall is high the output word holds; earlier stages keep
// filling until all three are full, then in_stall rises.
// Reset empties the pipeline and loads source_channels=2,
// target_mode=1 (stereo), sample_format=1 (s16).
// Depends on acrfc_pkg, acrfc_mix, acrfc_enc and assert_macros.svh.
`include "assert_macros.svh"

module audio_channel_remix_format_convert_unit
    import acrfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  logic             in_valid,
    output logic             in_stall,
    input  sample_t          in_ch0,
    input  sample_t          in_ch1,
    input  sample_t          in_ch2,
    input  sample_t          in_ch3,
    input  sample_t          in_ch4,
    input  sample_t          in_ch5,
    input  logic             in_last,

    output logic             out_valid,
    input  logic             out_stall,
    output word_t            out_s0,
    output word_t            out_s1,
    output word_t            out_s2,
    output word_t            out_s3,
    output word_t            out_s4,
    output word_t            out_s5,
    output logic [2:0]       out_count,
    output logic             out_last
);

    logic [2:0] source_channels_reg;
    logic [3:0] target_mode_reg;
    logic [2:0] sample_format_reg;
    logic       cfg_write;

    logic                v1_reg;
    sample_t [NumCh-1:0] ch1_reg;
    logic                last1_reg;
    logic                v2_reg;
    mix_t                mix2_reg;
    logic                last2_reg;
    logic                v3_reg;
    word_t   [NumCh-1:0] word3_reg;
    logic    [2:0]       count3_reg;
    logic                last3_reg;

    logic                adv1;
    logic                adv2;
    logic                adv3;
    mix_t                mix_next;
    word_t   [NumCh-1:0] word_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_channels_reg <= 3'd2;
            target_mode_reg     <= MODE_STEREO;
            sample_format_reg   <= FMT_S16;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SOURCE_CHANNELS: source_channels_reg <= pwdata[2:0];
                REG_TARGET_MODE:     target_mode_reg     <= pwdata[3:0];
                REG_SAMPLE_FORMAT:   sample_format_reg   <= pwdata[2:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SOURCE_CHANNELS: prdata = {29'd0, source_channels_reg};
            REG_TARGET_MODE:     prdata = {28'd0, target_mode_reg};
            REG_SAMPLE_FORMAT:   prdata = {29'd0, sample_format_reg};
            default:             prdata = '0;
        endcase
    end

    // a stage advances when the one after it is empty or advancing
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    acrfc_mix u_mix (
        .ch              (ch1_reg),
        .source_channels (source_channels_reg),
        .target_mode     (target_mode_reg),
        .mix             (mix_next)
    );

    acrfc_enc u_enc (
        .mix           (mix2_reg),
        .sample_format (sample_format_reg),
        .word          (word_next)
    );

    // payload: load only on advance so stalled words hold
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            ch1_reg   <= {in_ch5, in_ch4, in_ch3, in_ch2, in_ch1, in_ch0};
            last1_reg <= in_last;
        end
        if (adv2 && v1_reg)
        begin
            mix2_reg  <= mix_next;
            last2_reg <= last1_reg;
        end
        if (adv3 && v2_reg)
        begin
            word3_reg  <= word_next;
            count3_reg <= mix2_reg.cnt;
            last3_reg  <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_s0    = word3_reg[0];
    assign out_s1    = word3_reg[1];
    assign out_s2    = word3_reg[2];
    assign out_s3    = word3_reg[3];
    assign out_s4    = word3_reg[4];
    assign out_s5    = word3_reg[5];
    assign out_count = count3_reg;
    assign out_last  = last3_reg;

    `ASSERT_SAME_CYCLE(a_count_range, clk, rst_n, out_valid, (out_count != 3'd0) && (out_count != 3'd7))
    `ASSERT_SAME_CYCLE(a_unused_zero, clk, rst_n, out_valid && (out_count != 3'd6), out_s5 == '0)
    `ASSERT_NEXT_CYCLE(a_mid_hold, clk, rst_n, v2_reg && !adv3, v2_reg)
    `ASSERT_SAME_CYCLE(a_stall_full, clk, rst_n, in_stall, v1_reg && v2_reg && v3_reg)

endmodule
